// ----- rtl/tte_pkg.sv -----
`timescale 1ns / 1ps

package tte_pkg;

    // width of cursor and cell index fields
    localparam int IDX_W = 4;

    // action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // stream characters
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;

    // escape parser state
    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_CARET = 2'd1,
        ESC_ROW   = 2'd2
    } esc_t;

    // screen operation carried to the row edit stage
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PUT   = 3'd1,
        OP_ERASE = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // where the row edit stage takes its row from
    typedef enum logic [1:0] {
        SRC_RAM   = 2'd0,
        SRC_BYP   = 2'd1,
        SRC_BLANK = 2'd2
    } src_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       byte_in;
        logic [IDX_W-1:0] read_row;
        logic [IDX_W-1:0] read_col;
    } item_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [IDX_W-1:0] cursor_row;
        logic [IDX_W-1:0] cursor_col;
        logic             insert_on;
        logic [1:0]       escape_phase;
    } result_t;

    // decoded item handed from the control stage to the row edit stage
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [7:0]       ch;
        logic             ins;
        logic [IDX_W-1:0] rd_col;
        logic             rd_ok;
        logic [IDX_W-1:0] cursor_row;
        logic [IDX_W-1:0] cursor_col;
        logic             insert_on;
        esc_t             phase;
    } edit_t;

endpackage

// ----- rtl/text_terminal_escape_interpreter.sv -----
`timescale 1ns / 1ps

// Character-cell terminal with caret escapes, ROWS x COLS cells.
// Input channel item_valid / item_ready / item: one action per item, either
// a stream byte, a start of a new screen, or the read of one cell.
// Output channel result_valid / result_ready / result: exactly one result per
// item, in order, giving the cell read (zero otherwise), the cursor, the
// insert mode and the escape parser phase after that item.
// The control stage decodes an accepted item and reads its row (the cursor row,
// or the row of a cell read) from the screen memory; the row edit stage then
// rewrites the whole row, writes it back for a put or erase, and fills the
// result register. One item per cycle is sustained while results are taken; a
// row read just after a write to the same row is forwarded from the edit stage.
// Clear screen and start only drop the per-row valid bits, so a cleared row
// reads as spaces until written again.
// Reset clears the cursor, the modes, the parser and all row valid bits; the
// block accepts items in the first cycle after reset.
// When the receiver stalls the result register holds, one more item may sit in
// the edit stage, and item_ready then drops until result_ready returns.

module text_terminal_escape_interpreter #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tte_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output tte_pkg::result_t result
);

    localparam int ROW_AW = $clog2(ROWS);
    localparam int ROW_W  = COLS * 8;

    logic             in_accept;
    logic             out_free;
    logic             s2_adv;

    tte_pkg::edit_t   edit;
    logic             s2_valid_reg;
    tte_pkg::edit_t   s2_reg;
    tte_pkg::src_t    src_reg, src_next;
    logic [ROW_W-1:0] byp_reg;

    logic             out_valid_reg;
    tte_pkg::result_t out_reg;

    logic [ROWS-1:0]  row_vld_reg, row_vld_next;

    logic [ROW_AW-1:0] rd_addr;
    logic [ROW_AW-1:0] wr_row;
    logic              wr_en;
    logic              clr_en;
    logic [ROW_W-1:0]  ram_q;
    logic [ROW_W-1:0]  row_new;
    logic [7:0]        cell_char;

    // handshake and stage advance
    assign out_free   = !out_valid_reg || result_ready;
    assign s2_adv     = s2_valid_reg && out_free;
    assign item_ready = !s2_valid_reg || out_free;
    assign in_accept  = item_valid && item_ready;

    // control stage
    tte_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (item),
        .edit   (edit)
    );

    assign rd_addr = edit.row[ROW_AW-1:0];
    assign wr_row  = s2_reg.row[ROW_AW-1:0];
    assign wr_en   = s2_adv && ((s2_reg.op == tte_pkg::OP_PUT) || (s2_reg.op == tte_pkg::OP_ERASE));
    assign clr_en  = s2_adv && (s2_reg.op == tte_pkg::OP_CLEAR);

    // screen rows
    tte_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_screen (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_row),
        .wdata (row_new),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // row valid bits after this cycle's clear or write
    always_comb
    begin
        row_vld_next = clr_en ? '0 : row_vld_reg;
        if (wr_en)
        begin
            row_vld_next[wr_row] = 1'b1;
        end
    end

    // row source for the item entering the edit stage
    always_comb
    begin
        if (wr_en && (wr_row == rd_addr))
        begin
            src_next = tte_pkg::SRC_BYP;
        end
        else if (!row_vld_next[rd_addr])
        begin
            src_next = tte_pkg::SRC_BLANK;
        end
        else
        begin
            src_next = tte_pkg::SRC_RAM;
        end
    end

    // row edit stage
    tte_row_edit #(
        .COLS (COLS)
    ) u_row_edit (
        .edit      (s2_reg),
        .src       (src_reg),
        .ram_q     (ram_q),
        .byp_q     (byp_reg),
        .row_new   (row_new),
        .cell_char (cell_char)
    );

    // valid bits and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_vld_reg <= row_vld_next;
            if (in_accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_reg  <= edit;
            src_reg <= src_next;
            byp_reg <= row_new;
        end
        if (s2_adv)
        begin
            out_reg.cell_char    <= cell_char;
            out_reg.cursor_row   <= s2_reg.cursor_row;
            out_reg.cursor_col   <= s2_reg.cursor_col;
            out_reg.insert_on    <= s2_reg.insert_on;
            out_reg.escape_phase <= s2_reg.phase;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/tte_ram.sv -----
`timescale 1ns / 1ps

module tte_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tte_ctrl.sv -----
`timescale 1ns / 1ps

module tte_ctrl #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  tte_pkg::item_t item,
    output tte_pkg::edit_t edit
);

    localparam logic [tte_pkg::IDX_W-1:0] ROW_LAST = tte_pkg::IDX_W'(ROWS - 1);
    localparam logic [tte_pkg::IDX_W-1:0] COL_LAST = tte_pkg::IDX_W'(COLS - 1);
    localparam logic [tte_pkg::IDX_W-1:0] ROW_CNT  = tte_pkg::IDX_W'(ROWS);
    localparam logic [tte_pkg::IDX_W-1:0] COL_CNT  = tte_pkg::IDX_W'(COLS);

    logic [tte_pkg::IDX_W-1:0] row_reg, row_next;
    logic [tte_pkg::IDX_W-1:0] col_reg, col_next;
    logic                      ovr_reg, ovr_next;
    logic [tte_pkg::IDX_W-1:0] held_reg, held_next;
    tte_pkg::esc_t             esc_reg, esc_next;

    logic                      is_digit;
    logic [tte_pkg::IDX_W-1:0] digit;
    logic                      do_put, do_cmd, do_goto, do_start, do_read;

    assign is_digit = (item.byte_in >= tte_pkg::CH_ZERO) && (item.byte_in <= tte_pkg::CH_NINE);
    assign digit    = item.byte_in[tte_pkg::IDX_W-1:0];

    // escape parser next state
    always_comb
    begin
        esc_next = esc_reg;
        case (item.action)
            tte_pkg::ACT_BYTE:
            begin
                case (esc_reg)
                    tte_pkg::ESC_IDLE:
                        esc_next = (item.byte_in == tte_pkg::CH_CARET) ? tte_pkg::ESC_CARET
                                                                       : tte_pkg::ESC_IDLE;
                    tte_pkg::ESC_CARET:
                        esc_next = is_digit ? tte_pkg::ESC_ROW : tte_pkg::ESC_IDLE;
                    tte_pkg::ESC_ROW:
                        esc_next = tte_pkg::ESC_IDLE;
                    default:
                        esc_next = tte_pkg::ESC_IDLE;
                endcase
            end
            tte_pkg::ACT_START:
                esc_next = tte_pkg::ESC_IDLE;
            default:
                esc_next = esc_reg;
        endcase
    end

    // what the item asks for, given the parser state
    always_comb
    begin
        do_put   = 1'b0;
        do_cmd   = 1'b0;
        do_goto  = 1'b0;
        do_start = 1'b0;
        do_read  = 1'b0;
        case (item.action)
            tte_pkg::ACT_BYTE:
            begin
                case (esc_reg)
                    tte_pkg::ESC_IDLE:
                        do_put = (item.byte_in != tte_pkg::CH_CARET)
                                 && (item.byte_in != tte_pkg::CH_LF);
                    tte_pkg::ESC_CARET:
                    begin
                        do_put = (item.byte_in == tte_pkg::CH_CARET);
                        do_cmd = (item.byte_in != tte_pkg::CH_CARET) && !is_digit
                                 && (item.byte_in != tte_pkg::CH_LF);
                    end
                    tte_pkg::ESC_ROW:
                        do_goto = is_digit;
                    default:
                        do_put = 1'b0;
                endcase
            end
            tte_pkg::ACT_START:
                do_start = 1'b1;
            tte_pkg::ACT_READ:
                do_read = 1'b1;
            default:
                do_put = 1'b0;
        endcase
    end

    // cursor, mode and screen operation
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        ovr_next  = ovr_reg;
        held_next = held_reg;

        edit.op     = tte_pkg::OP_NONE;
        edit.row    = row_reg;
        edit.col    = col_reg;
        edit.ch     = item.byte_in;
        edit.ins    = !ovr_reg && (col_reg != COL_LAST);
        edit.rd_col = item.read_col;
        edit.rd_ok  = 1'b0;

        if ((item.action == tte_pkg::ACT_BYTE) && (esc_reg == tte_pkg::ESC_CARET) && is_digit)
        begin
            held_next = digit;
        end

        // print at cursor, then advance but stay in the last column
        if (do_put)
        begin
            edit.op = tte_pkg::OP_PUT;
            if (col_reg != COL_LAST)
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // letter commands
        if (do_cmd)
        begin
            case (item.byte_in)
                tte_pkg::CH_B: col_next = '0;
                tte_pkg::CH_C: edit.op = tte_pkg::OP_CLEAR;
                tte_pkg::CH_D:
                begin
                    if (row_reg != ROW_LAST)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                tte_pkg::CH_E: edit.op = tte_pkg::OP_ERASE;
                tte_pkg::CH_H:
                begin
                    row_next = '0;
                    col_next = '0;
                end
                tte_pkg::CH_I: ovr_next = 1'b0;
                tte_pkg::CH_L:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                tte_pkg::CH_O: ovr_next = 1'b1;
                tte_pkg::CH_R:
                begin
                    if (col_reg != COL_LAST)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                tte_pkg::CH_U:
                begin
                    if (row_reg != '0)
                    begin
                        row_next = row_reg - 1'b1;
                    end
                end
                default: ovr_next = ovr_reg;
            endcase
        end

        // cursor placement, clamped to the screen
        if (do_goto)
        begin
            row_next = (held_reg > ROW_LAST) ? ROW_LAST : held_reg;
            col_next = (digit > COL_LAST) ? COL_LAST : digit;
        end

        if (do_start)
        begin
            edit.op   = tte_pkg::OP_CLEAR;
            row_next  = '0;
            col_next  = '0;
            ovr_next  = 1'b1;
            held_next = '0;
        end

        // cell read, row forced to zero when off screen
        if (do_read)
        begin
            edit.op    = tte_pkg::OP_READ;
            edit.rd_ok = (item.read_row < ROW_CNT) && (item.read_col < COL_CNT);
            edit.row   = edit.rd_ok ? item.read_row : '0;
        end

        edit.cursor_row = row_next;
        edit.cursor_col = col_next;
        edit.insert_on  = !ovr_next;
        edit.phase      = esc_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            ovr_reg  <= 1'b1;
            held_reg <= '0;
            esc_reg  <= tte_pkg::ESC_IDLE;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            ovr_reg  <= ovr_next;
            held_reg <= held_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

// ----- rtl/tte_row_edit.sv -----
`timescale 1ns / 1ps

module tte_row_edit #(
    parameter int COLS = 10
) (
    input  tte_pkg::edit_t    edit,
    input  tte_pkg::src_t     src,
    input  logic [COLS*8-1:0] ram_q,
    input  logic [COLS*8-1:0] byp_q,
    output logic [COLS*8-1:0] row_new,
    output logic [7:0]        cell_char
);

    localparam int ROW_W = COLS * 8;

    logic [ROW_W-1:0] row_in;
    logic [ROW_W-1:0] row_shift;

    // current row contents: memory, last written row, or blank
    always_comb
    begin
        case (src)
            tte_pkg::SRC_RAM:   row_in = ram_q;
            tte_pkg::SRC_BYP:   row_in = byp_q;
            default:            row_in = {COLS{tte_pkg::CH_SPACE}};
        endcase
    end

    // row moved one cell right, for insert mode
    assign row_shift = {row_in[ROW_W-9:0], tte_pkg::CH_SPACE};

    // per-cell edit
    always_comb
    begin
        row_new = row_in;
        for (int k = 0; k < COLS; k++)
        begin
            case (edit.op)
                tte_pkg::OP_PUT:
                begin
                    if (tte_pkg::IDX_W'(k) == edit.col)
                    begin
                        row_new[8*k +: 8] = edit.ch;
                    end
                    else if (edit.ins && (tte_pkg::IDX_W'(k) > edit.col))
                    begin
                        row_new[8*k +: 8] = row_shift[8*k +: 8];
                    end
                end
                tte_pkg::OP_ERASE:
                begin
                    if (tte_pkg::IDX_W'(k) >= edit.col)
                    begin
                        row_new[8*k +: 8] = tte_pkg::CH_SPACE;
                    end
                end
                default: row_new[8*k +: 8] = row_in[8*k +: 8];
            endcase
        end
    end

    // cell read
    always_comb
    begin
        cell_char = '0;
        if ((edit.op == tte_pkg::OP_READ) && edit.rd_ok)
        begin
            for (int k = 0; k < COLS; k++)
            begin
                if (tte_pkg::IDX_W'(k) == edit.rd_col)
                begin
                    cell_char = row_in[8*k +: 8];
                end
            end
        end
    end

endmodule

// ----- rtl/tte_checker.sv -----
`timescale 1ns / 1ps

module tte_checker #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input tte_pkg::result_t result
);

    logic [1:0] pend_reg;
    logic       item_acc;
    logic       res_acc;

    assign item_acc = item_valid && item_ready;
    assign res_acc  = result_valid && result_ready;

    // items taken but results not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (item_acc && !res_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (res_acc && !item_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // the cursor never leaves the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cursor_row < 4'(ROWS)) && (result.cursor_col < 4'(COLS)))
        else $error("cursor off screen");

    // no result without an item behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result without item");

    // at most two items in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items in flight");

    // with both stages full, a stalled output blocks the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd2) && !result_ready |-> !item_ready)
        else $error("item taken with no room");

endmodule

bind text_terminal_escape_interpreter tte_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
